@@ rtl/lapc_pkg.sv @@
package lapc_pkg;

    // Field widths.
    localparam int ANGLE_W    = 15;
    localparam int RANGE_W    = 14;
    localparam int POS_W      = 15;
    localparam int ID_W       = 12;
    localparam int DIST_W     = 14;
    localparam int GAP_W      = 15;
    localparam int MIN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PTS  = 2'd2;

    localparam logic [DIST_W-1:0] DIST_THR_RESET = 14'd180;
    localparam logic [GAP_W-1:0]  MAX_GAP_RESET  = 15'd128;
    localparam logic [MIN_W-1:0]  MIN_PTS_RESET  = 7'd3;

    // Cluster buffer.
    localparam int CLUSTER_DEPTH = 32;
    localparam int DEPTH_AW      = $clog2(CLUSTER_DEPTH);
    localparam int CNT_W         = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [ID_W-1:0]  ID_MAX  = {ID_W{1'b1}};

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Sine table and bearing to table step conversion.
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER_STEPS   = 1 << (SINE_TABLE_BITS - 2);
    localparam int ANGLE_TURN      = 23040;
    localparam int ANGLE_ROUND     = ANGLE_TURN / 2;
    localparam int SIN_W           = 15;
    localparam int Q14_SHIFT       = 14;
    localparam int Q14_ROUND       = 1 << (Q14_SHIFT - 1);
    localparam int IDX_NUM_W       = ANGLE_W + SINE_TABLE_BITS;
    localparam int IDX_SHIFT       = IDX_NUM_W + 16;
    localparam int IDX_RECIP_W     = IDX_SHIFT - 13;
    localparam int IDX_PROD_W      = IDX_NUM_W + IDX_RECIP_W;
    localparam longint IDX_RECIP   =
        ((longint'(1) << IDX_SHIFT) + ANGLE_TURN - 1) / ANGLE_TURN;
    localparam int SCALE_W         = RANGE_W + SIN_W;
    localparam int DIFF_W          = POS_W + 1;
    localparam int SQ_W            = 2 * DIFF_W;

    typedef logic [SIN_W-1:0] sine_tab_t [0:QUARTER_STEPS];

    typedef struct packed {
        logic [DIST_W-1:0] dist_thr;
        logic [GAP_W-1:0]  max_gap;
        logic [MIN_W-1:0]  min_pts;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    brk;
        logic                    last;
    } cmd_t;

    // Quarter-wave sine in Q14, built from a Taylor series in Q30 radians.
    function automatic sine_tab_t build_sine();
        sine_tab_t   tab;
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        logic [63:0] q14;
        for (int k = 0; k <= QUARTER_STEPS; k++) begin
            x    = (64'd1686629713 * 64'(k)) / QUARTER_STEPS;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                case (n)
                    1:       term = term / 6;
                    2:       term = term / 20;
                    3:       term = term / 42;
                    4:       term = term / 72;
                    5:       term = term / 110;
                    6:       term = term / 156;
                    default: term = term / 210;
                endcase
                if ((n % 2) == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            q14 = (64'(sum) + 64'd32768) >> 16;
            if (q14 > 64'd16384) q14 = 64'd16384;
            tab[k] = SIN_W'(q14);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

    // Sine of a table step: sign bit above the Q14 magnitude.
    function automatic logic [SIN_W:0] sine_at(input logic [SINE_TABLE_BITS-1:0] step);
        logic [1:0]                   quad;
        logic [SINE_TABLE_BITS-3:0]   r;
        logic [SINE_TABLE_BITS-2:0]   mirror;
        logic [SIN_W-1:0]             mag;
        quad   = step[SINE_TABLE_BITS-1 -: 2];
        r      = step[SINE_TABLE_BITS-3:0];
        mirror = (SINE_TABLE_BITS-1)'(QUARTER_STEPS) - {1'b0, r};
        if (quad[0]) mag = SINE_TAB[mirror];
        else mag = SINE_TAB[r];
        return {quad[1], mag};
    endfunction

endpackage

@@ rtl/lapc_if.sv @@
interface lapc_in_if import lapc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle;
    logic [RANGE_W-1:0] range_mm;
    logic               last_of_scan;

    modport source (output valid, angle, range_mm, last_of_scan, input ready);
    modport sink   (input valid, angle, range_mm, last_of_scan, output ready);
endinterface

interface lapc_out_if import lapc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ID_W-1:0]         cluster_id;
    logic                    last_in_cluster;
    logic                    truncated;

    modport source (output valid, pos_x, pos_y, cluster_id, last_in_cluster, truncated,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, cluster_id, last_in_cluster, truncated,
                    output ready);
endinterface

@@ rtl/lapc_front.sv @@
module lapc_front import lapc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    lapc_in_if.sink    in_pt,
    output cmd_t       push_cmd,
    output logic       push_valid,
    input  logic       push_ready
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_SQR  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]                state_reg;
    logic [ANGLE_W-1:0]        angle_reg;
    logic [RANGE_W-1:0]        range_reg;
    logic                      last_reg;
    logic [IDX_PROD_W-1:0]     idx_prod_reg;
    logic [SCALE_W-1:0]        x_prod_reg;
    logic [SCALE_W-1:0]        y_prod_reg;
    logic                      x_neg_reg;
    logic                      y_neg_reg;
    logic signed [POS_W-1:0]   pos_x_reg;
    logic signed [POS_W-1:0]   pos_y_reg;
    logic [SQ_W-1:0]           dx2_reg;
    logic [SQ_W-1:0]           dy2_reg;
    logic [2*DIST_W-1:0]       thr2_reg;
    logic                      have_prev_reg;
    logic [ANGLE_W-1:0]        prev_angle_reg;
    logic signed [POS_W-1:0]   prev_x_reg;
    logic signed [POS_W-1:0]   prev_y_reg;

    logic [IDX_NUM_W-1:0]       idx_num;
    logic [IDX_PROD_W-1:0]      idx_prod;
    logic [SINE_TABLE_BITS-1:0] sin_step;
    logic [SINE_TABLE_BITS-1:0] cos_step;
    logic [SIN_W:0]             sin_val;
    logic [SIN_W:0]             cos_val;
    logic [SCALE_W-1:0]         x_rnd;
    logic [SCALE_W-1:0]         y_rnd;
    logic signed [DIFF_W-1:0]   x_mag;
    logic signed [DIFF_W-1:0]   y_mag;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic signed [DIFF_W-1:0]   dx;
    logic signed [DIFF_W-1:0]   dy;
    logic signed [DIFF_W:0]     gap;
    logic [SQ_W:0]              d2;
    logic                       same;

    always_comb
    begin
        idx_num  = (IDX_NUM_W'(in_pt.angle) << SINE_TABLE_BITS) + IDX_NUM_W'(ANGLE_ROUND);
        idx_prod = IDX_PROD_W'(idx_num) * IDX_PROD_W'(IDX_RECIP);
        sin_step = idx_prod_reg[IDX_SHIFT +: SINE_TABLE_BITS];
        cos_step = sin_step + SINE_TABLE_BITS'(QUARTER_STEPS);
        sin_val  = sine_at(sin_step);
        cos_val  = sine_at(cos_step);
        x_rnd    = x_prod_reg + SCALE_W'(Q14_ROUND);
        y_rnd    = y_prod_reg + SCALE_W'(Q14_ROUND);
        x_mag    = {1'b0, x_rnd[Q14_SHIFT +: POS_W]};
        y_mag    = {1'b0, y_rnd[Q14_SHIFT +: POS_W]};
        pos_x    = x_neg_reg ? POS_W'(-x_mag) : POS_W'(x_mag);
        pos_y    = y_neg_reg ? POS_W'(-y_mag) : POS_W'(y_mag);
        dx       = DIFF_W'(pos_x) - DIFF_W'(prev_x_reg);
        dy       = DIFF_W'(pos_y) - DIFF_W'(prev_y_reg);
        gap      = $signed({2'b00, angle_reg}) - $signed({2'b00, prev_angle_reg});
        d2       = (SQ_W + 1)'(dx2_reg) + (SQ_W + 1)'(dy2_reg);
        same     = (gap <= $signed({2'b00, cfg.max_gap}))
                   && (d2 <= (SQ_W + 1)'(thr2_reg));
    end

    assign in_pt.ready = (state_reg == F_IDLE);
    assign push_valid  = (state_reg == F_PUSH);

    always_comb
    begin
        push_cmd.pos_x = pos_x_reg;
        push_cmd.pos_y = pos_y_reg;
        push_cmd.brk   = have_prev_reg && !same;
        push_cmd.last  = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            have_prev_reg  <= 1'b0;
            prev_angle_reg <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_pt.valid) state_reg <= F_MUL;
                end
                F_MUL:   state_reg <= F_SQR;
                F_SQR:   state_reg <= F_PUSH;
                F_PUSH:
                begin
                    if (push_ready)
                    begin
                        state_reg      <= F_IDLE;
                        have_prev_reg  <= !last_reg;
                        prev_angle_reg <= angle_reg;
                        prev_x_reg     <= pos_x_reg;
                        prev_y_reg     <= pos_y_reg;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_pt.valid)
        begin
            angle_reg    <= in_pt.angle;
            range_reg    <= in_pt.range_mm;
            last_reg     <= in_pt.last_of_scan;
            idx_prod_reg <= idx_prod;
        end
        if (state_reg == F_MUL)
        begin
            x_prod_reg <= SCALE_W'(range_reg) * SCALE_W'(cos_val[SIN_W-1:0]);
            y_prod_reg <= SCALE_W'(range_reg) * SCALE_W'(sin_val[SIN_W-1:0]);
            x_neg_reg  <= cos_val[SIN_W];
            y_neg_reg  <= sin_val[SIN_W];
            thr2_reg   <= (2*DIST_W)'(cfg.dist_thr) * (2*DIST_W)'(cfg.dist_thr);
        end
        if (state_reg == F_SQR)
        begin
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            dx2_reg   <= SQ_W'(dx) * SQ_W'(dx);
            dy2_reg   <= SQ_W'(dy) * SQ_W'(dy);
        end
    end

endmodule

@@ rtl/lapc_queue.sv @@
module lapc_queue import lapc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t push_cmd,
    input  logic push_valid,
    output logic push_ready,
    output cmd_t pop_cmd,
    output logic pop_valid,
    input  logic pop_ready
);

    cmd_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] fill_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (fill_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push) fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) entries_reg[wr_ptr_reg] <= push_cmd;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue fill count beyond its depth");
`endif

endmodule

@@ rtl/lapc_back.sv @@
module lapc_back import lapc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  cmd_t       pop_cmd,
    input  logic       pop_valid,
    output logic       pop_ready,
    lapc_out_if.source out_pt
);

    localparam logic [2:0] B_IDLE   = 3'd0;
    localparam logic [2:0] B_CLOSE1 = 3'd1;
    localparam logic [2:0] B_STORE  = 3'd2;
    localparam logic [2:0] B_CLOSE2 = 3'd3;
    localparam logic [2:0] B_RD     = 3'd4;
    localparam logic [2:0] B_WR     = 3'd5;

    logic [2*POS_W-1:0] mem [CLUSTER_DEPTH];

    logic [2:0]              state_reg;
    cmd_t                    cmd_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [ID_W-1:0]         id_reg;
    logic [DEPTH_AW-1:0]     emit_idx_reg;
    logic [DEPTH_AW-1:0]     emit_last_reg;
    logic                    trunc_reg;
    logic                    ret_store_reg;
    logic [2*POS_W-1:0]      rd_data_reg;
    logic                    out_valid_reg;
    logic signed [POS_W-1:0] out_x_reg;
    logic signed [POS_W-1:0] out_y_reg;
    logic [ID_W-1:0]         out_id_reg;
    logic                    out_last_reg;
    logic                    out_trunc_reg;

    logic [MIN_W-1:0] need;
    logic             emit_ok;
    logic [CNT_W-1:0] stored_m1;
    logic             out_free;
    logic             mem_we;

    always_comb
    begin
        need      = (cfg.min_pts < MIN_W'(2)) ? MIN_W'(2) : cfg.min_pts;
        emit_ok   = (count_reg >= CNT_W'(need));
        stored_m1 = (count_reg > CNT_W'(CLUSTER_DEPTH)) ? CNT_W'(CLUSTER_DEPTH - 1)
                    : count_reg - 1'b1;
        out_free  = !out_valid_reg || out_pt.ready;
        mem_we    = (state_reg == B_STORE) && (count_reg < CNT_W'(CLUSTER_DEPTH));
    end

    assign pop_ready              = (state_reg == B_IDLE);
    assign out_pt.valid           = out_valid_reg;
    assign out_pt.pos_x           = out_x_reg;
    assign out_pt.pos_y           = out_y_reg;
    assign out_pt.cluster_id      = out_id_reg;
    assign out_pt.last_in_cluster = out_last_reg;
    assign out_pt.truncated       = out_trunc_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[count_reg[DEPTH_AW-1:0]] <= {cmd_reg.pos_x, cmd_reg.pos_y};
        if (state_reg == B_RD) rd_data_reg <= mem[emit_idx_reg];
        if (state_reg == B_IDLE && pop_valid) cmd_reg <= pop_cmd;
        if ((state_reg == B_CLOSE1 && cmd_reg.brk && emit_ok)
            || (state_reg == B_CLOSE2 && emit_ok))
        begin
            emit_last_reg <= stored_m1[DEPTH_AW-1:0];
            trunc_reg     <= (count_reg > CNT_W'(CLUSTER_DEPTH));
            ret_store_reg <= (state_reg == B_CLOSE1);
        end
        if (state_reg == B_WR && out_free)
        begin
            out_x_reg     <= rd_data_reg[POS_W +: POS_W];
            out_y_reg     <= rd_data_reg[0 +: POS_W];
            out_id_reg    <= id_reg;
            out_last_reg  <= (emit_idx_reg == emit_last_reg);
            out_trunc_reg <= trunc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            id_reg        <= ID_W'(1);
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A beat taken this cycle empties the output register unless the
            // emission step refills it at the same edge.
            if (out_valid_reg && out_pt.ready && !(state_reg == B_WR && out_free))
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid) state_reg <= B_CLOSE1;
                end
                B_CLOSE1:
                begin
                    if (cmd_reg.brk && emit_ok)
                    begin
                        emit_idx_reg <= '0;
                        state_reg    <= B_RD;
                    end
                    else
                    begin
                        if (cmd_reg.brk) count_reg <= '0;
                        state_reg <= B_STORE;
                    end
                end
                B_STORE:
                begin
                    if (count_reg != CNT_MAX) count_reg <= count_reg + 1'b1;
                    state_reg <= cmd_reg.last ? B_CLOSE2 : B_IDLE;
                end
                B_CLOSE2:
                begin
                    if (emit_ok)
                    begin
                        emit_idx_reg <= '0;
                        state_reg    <= B_RD;
                    end
                    else
                    begin
                        count_reg <= '0;
                        id_reg    <= ID_W'(1);
                        state_reg <= B_IDLE;
                    end
                end
                B_RD:    state_reg <= B_WR;
                B_WR:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (emit_idx_reg == emit_last_reg)
                        begin
                            count_reg <= '0;
                            if (ret_store_reg)
                            begin
                                if (id_reg != ID_MAX) id_reg <= id_reg + 1'b1;
                                state_reg <= B_STORE;
                            end
                            else
                            begin
                                id_reg    <= ID_W'(1);
                                state_reg <= B_IDLE;
                            end
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_reg + 1'b1;
                            state_reg    <= B_RD;
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        id_reg != '0)
        else $error("cluster number reached zero");

    a_emit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_RD || state_reg == B_WR) |-> emit_idx_reg <= emit_last_reg)
        else $error("emission index ran past the stored points");

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_WR))
        else $error("output beat loaded outside the emission step");
`endif

endmodule

@@ rtl/lidar_adjacent_point_clustering_unit.sv @@
// Lidar breakpoint segmentation. Points arrive one beat at a time on in_pt,
// sorted by bearing; each is turned into x,y millimetres through a quarter-wave
// sine table and grouped with its predecessor while the bearing step and the
// Cartesian gap stay within the configured limits. A closed cluster of at least
// max(min_cluster_points, 2) points leaves on out_pt, one beat per point, its
// number counting from 1 within each scan; points beyond the 32-entry buffer
// are counted but dropped and the run is flagged truncated. The front section
// handles a point in order (accept, table and scaling multiply, distance
// squares, decision) and takes no new point until that one enters the queue.
// The back stores a point by take, decide and write, and emits a cluster one
// beat per stored point (a registered buffer read, then an output load that
// waits while out_pt stalls). A two-entry queue lets the front take new points
// while the back is emitting. Configuration writes are accepted on any cycle and
// must be made only while the block is idle; register 0 is the distance
// threshold, 1 the largest bearing step and 2 the minimum cluster size.
module lidar_adjacent_point_clustering_unit import lapc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lapc_in_if.sink               in_pt,
    lapc_out_if.source            out_pt
);

    // Configuration registers, reset to the documented defaults.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dist_thr <= DIST_THR_RESET;
            cfg_reg.max_gap  <= MAX_GAP_RESET;
            cfg_reg.min_pts  <= MIN_PTS_RESET;
        end
        else if (cfg_wr_en)
        begin
            // Writes to an index beyond the register list are ignored.
            case (cfg_index)
                CFG_DIST_THR: cfg_reg.dist_thr <= cfg_data[DIST_W-1:0];
                CFG_MAX_GAP:  cfg_reg.max_gap  <= cfg_data[GAP_W-1:0];
                CFG_MIN_PTS:  cfg_reg.min_pts  <= cfg_data[MIN_W-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The front decides, for each point, whether it breaks the open cluster;
    // the back owns the cluster buffer and the numbering.
    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    lapc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_pt      (in_pt),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready)
    );

    lapc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (back_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    lapc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_cmd   (back_cmd),
        .pop_valid (back_valid),
        .pop_ready (back_ready),
        .out_pt    (out_pt)
    );

endmodule
